// ----- design/iee_pkg.sv -----
// shared types, codes and helper functions for the infix expression evaluator
// no dependencies; imported by every module of the block
package iee_pkg;

  localparam int VALUE_STACK_DEPTH_DEF    = 16;
  localparam int OPERATOR_STACK_DEPTH_DEF = 16;
  localparam int FRACTION_BITS_DEF        = 32;

  localparam int VAL_W = 64;
  localparam int DVD_W = 128;

  // operator codes held on the operator stack
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_LPAR = 3'd4;

  // error codes
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
  localparam logic [2:0] ERR_OPERAND   = 3'd2;
  localparam logic [2:0] ERR_DIV_ZERO  = 3'd3;
  localparam logic [2:0] ERR_BAD_CHAR  = 3'd4;
  localparam logic [2:0] ERR_SATURATED = 3'd5;

  // characters
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [63:0] DIGIT_CAP       = 64'd1000000000000000000;
  localparam logic [4:0]  MAX_FRAC_DIGITS = 5'd18;
  localparam logic [63:0] SIGN_MIN        = 64'h8000_0000_0000_0000;
  localparam logic [63:0] SIGN_MAX        = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef enum logic [2:0] {
    CLS_DIGIT, CLS_POINT, CLS_SPACE, CLS_LPAR, CLS_RPAR, CLS_OP, CLS_BAD
  } char_cls_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic add_digit;
    logic add_point;
    logic conv_start;
    logic conv_push;
    logic push_lpar;
    logic push_zero;
    logic push_op;
    logic rpar_close;
    logic flag_bad;
    logic op_rd;
    logic op_pop;
    logic flag_miss;
    logic val_rd_top;
    logic val_rd_second;
    logic cap_b;
    logic cap_a;
    logic exec;
    logic push_res;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic      fatal;
    char_cls_t cls;
    logic      last;
    logic      in_number;
    logic      sub_expect;
    logic      oc_zero;
    logic      top_lpar;
    logic      prec_ge;
    logic      cur_lpar;
    logic      vc_lt2;
    logic      div_zero;
    logic      long_op;
    logic      unit_done;
    logic      out_free;
  } sts_t;

  function automatic char_cls_t char_class(input logic [7:0] c);
    char_cls_t k;
    if (c >= CH_ZERO && c <= CH_NINE) k = CLS_DIGIT;
    else if (c == CH_POINT) k = CLS_POINT;
    else if (c == CH_SPACE) k = CLS_SPACE;
    else if (c == CH_LPAR) k = CLS_LPAR;
    else if (c == CH_RPAR) k = CLS_RPAR;
    else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH) k = CLS_OP;
    else k = CLS_BAD;
    return k;
  endfunction

  function automatic logic [2:0] char_op(input logic [7:0] c);
    logic [2:0] o;
    case (c)
      CH_MINUS: o = OP_SUB;
      CH_STAR:  o = OP_MUL;
      CH_SLASH: o = OP_DIV;
      default:  o = OP_ADD;
    endcase
    return o;
  endfunction

  function automatic logic [1:0] prec(input logic [2:0] o);
    logic [1:0] p;
    case (o)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  // keep the first hard error, a saturation only fills an empty slot
  function automatic logic [2:0] flag(input logic [2:0] cur, input logic [2:0] e);
    logic [2:0] r;
    r = cur;
    if (e == ERR_SATURATED) begin
      if (cur == ERR_OK) r = ERR_SATURATED;
    end else if (cur == ERR_OK || cur == ERR_SATURATED) begin
      r = e;
    end
    return r;
  endfunction

  function automatic logic is_fatal(input logic [2:0] e);
    return (e != ERR_OK) && (e != ERR_SATURATED);
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // {saturated, value}
  function automatic logic [64:0] from_mag(input logic [63:0] m, input logic neg);
    logic s;
    logic [63:0] v;
    if (neg) begin
      s = (m > SIGN_MIN);
      v = s ? SIGN_MIN : (64'd0 - m);
    end else begin
      s = m[63];
      v = s ? SIGN_MAX : m;
    end
    return {s, v};
  endfunction

  function automatic logic [63:0] pow_ten(input logic [4:0] i);
    logic [63:0] p;
    case (i)
      5'd0:  p = 64'd1;
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      default: p = 64'd1000000000000000000;
    endcase
    return p;
  endfunction

endpackage

// ----- design/iee_div.sv -----
// restoring divider, one quotient bit per cycle, 128-bit dividend by 64-bit divisor
// depends on iee_pkg
module iee_div import iee_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dvd,
  input  logic [63:0]      dsr,
  output logic             done,
  output logic [DVD_W-1:0] quo,
  output logic [63:0]      rem
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [63:0]      rem_r;
  logic [63:0]      dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [64:0]      rem_t;
  logic [64:0]      diff;
  logic             ge;

  assign rem_t = {rem_r, q_r[DVD_W-1]};
  assign ge    = rem_t >= {1'b0, dsr_r};
  assign diff  = rem_t - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dvd;
      rem_r <= '0;
      dsr_r <= dsr;
    end else if (busy_r) begin
      q_r   <= {q_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[63:0] : rem_t[63:0];
    end
  end

  assign done = done_r;
  assign quo  = q_r;
  assign rem  = rem_r;

endmodule

// ----- design/iee_dp.sv -----
// datapath: character latch, number accumulator, value and operator stacks,
// adder, multiplier and shared divider; depends on iee_pkg and iee_div
module iee_dp import iee_pkg::*; #(
  parameter int VALUE_STACK_DEPTH    = VALUE_STACK_DEPTH_DEF,
  parameter int OPERATOR_STACK_DEPTH = OPERATOR_STACK_DEPTH_DEF,
  parameter int FRACTION_BITS        = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_char,
  input  logic        in_last,
  input  cmd_t        cmd,
  output sts_t        st,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  output logic [2:0]  out_err
);

  localparam int VAW = (VALUE_STACK_DEPTH > 1) ? $clog2(VALUE_STACK_DEPTH) : 1;
  localparam int VCW = $clog2(VALUE_STACK_DEPTH + 1);
  localparam int OAW = (OPERATOR_STACK_DEPTH > 1) ? $clog2(OPERATOR_STACK_DEPTH) : 1;
  localparam int OCW = $clog2(OPERATOR_STACK_DEPTH + 1);

  logic [7:0]  char_r;
  logic        last_r;
  logic [63:0] acc_r;
  logic [4:0]  fd_r;
  logic        innum_r;
  logic        seen_r;
  logic        expect_r;
  logic [2:0]  err_r;
  logic [2:0]  err_nxt;
  logic [VCW-1:0] vc_r;
  logic [OCW-1:0] oc_r;
  logic [2:0]  op_cur_r;
  logic [2:0]  ord_r;
  logic [63:0] vrd_r;
  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] res_r;
  logic [63:0] res_nxt;
  logic        neg_r;
  logic        kind_conv_r;

  logic [63:0] vmem [VALUE_STACK_DEPTH];
  logic [2:0]  omem [OPERATOR_STACK_DEPTH];

  logic        out_valid_r;
  logic [63:0] out_value_r;
  logic [2:0]  out_err_r;

  // multiplier
  logic [63:0]  mx_r;
  logic [63:0]  my_r;
  logic [2:0]   mstep_r;
  logic         mbusy_r;
  logic         mdone_r;
  logic [63:0]  prod_r;
  logic [1:0]   psh_r;
  logic [127:0] macc_r;

  // divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [63:0]      div_dsr;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [63:0]      div_rem;

  logic        fatal;
  logic        vfull;
  logic        ofull;
  logic [2:0]  cop;
  logic        seen_eff;
  logic [63:0] acc_eff;
  logic [4:0]  fd_eff;
  logic [63:0] dig_t;
  logic [VCW-1:0] vc_m1;
  logic [VCW-1:0] vc_m2;
  logic [OCW-1:0] oc_m1;
  logic        do_vpush;
  logic [63:0] vpush_data;
  logic        do_opush;
  logic [2:0]  opush_code;
  logic [63:0] p10;
  logic [63:0] sum_ab;
  logic [63:0] dif_ab;
  logic        sat_nxt;
  logic [64:0] fm;
  logic [63:0] conv_v;
  logic        conv_rnd;
  logic [2:0]  emit_err;

  assign fatal    = is_fatal(err_r);
  assign vfull    = (vc_r == VCW'(VALUE_STACK_DEPTH));
  assign ofull    = (oc_r == OCW'(OPERATOR_STACK_DEPTH));
  assign cop      = char_op(char_r);
  assign seen_eff = innum_r & seen_r;
  assign acc_eff  = innum_r ? acc_r : 64'd0;
  assign fd_eff   = innum_r ? fd_r : 5'd0;
  assign dig_t    = (acc_eff << 3) + (acc_eff << 1) + 64'(4'(char_r - CH_ZERO));
  assign vc_m1    = vc_r - VCW'(1);
  assign vc_m2    = vc_r - VCW'(2);
  assign oc_m1    = oc_r - OCW'(1);
  assign p10      = pow_ten(fd_r);
  assign sum_ab   = a_r + b_r;
  assign dif_ab   = a_r - b_r;

  assign st.fatal      = fatal;
  assign st.cls        = char_class(char_r);
  assign st.last       = last_r;
  assign st.in_number  = innum_r;
  assign st.sub_expect = (cop == OP_SUB) && expect_r;
  assign st.oc_zero    = (oc_r == '0);
  assign st.top_lpar   = (ord_r == OP_LPAR);
  assign st.prec_ge    = prec(ord_r) >= prec(cop);
  assign st.cur_lpar   = (op_cur_r == OP_LPAR);
  assign st.vc_lt2     = (vc_r < VCW'(2));
  assign st.div_zero   = (op_cur_r == OP_DIV) && (b_r == 64'd0);
  assign st.long_op    = (op_cur_r == OP_MUL) || (op_cur_r == OP_DIV);
  assign st.unit_done  = div_done | mdone_r;
  assign st.out_free   = !out_valid_r || out_ready;

  // character latch
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      char_r <= in_char;
      last_r <= in_last;
    end
  end

  // arithmetic results and saturation
  always_comb begin
    res_nxt  = res_r;
    sat_nxt  = 1'b0;
    fm       = '0;
    conv_rnd = ({div_rem, 1'b0} >= {1'b0, p10});
    conv_v   = div_quo[63:0] + 64'(conv_rnd);
    if (div_done) begin
      if (kind_conv_r) begin
        if ((|div_quo[127:63]) || conv_v[63]) begin
          sat_nxt = 1'b1;
          res_nxt = SIGN_MAX;
        end else begin
          res_nxt = conv_v;
        end
      end else if (|div_quo[127:64]) begin
        sat_nxt = 1'b1;
        res_nxt = neg_r ? SIGN_MIN : SIGN_MAX;
      end else begin
        fm      = from_mag(div_quo[63:0], neg_r);
        sat_nxt = fm[64];
        res_nxt = fm[63:0];
      end
    end else if (mdone_r) begin
      if (|macc_r[127:64+FRACTION_BITS]) begin
        sat_nxt = 1'b1;
        res_nxt = neg_r ? SIGN_MIN : SIGN_MAX;
      end else begin
        fm      = from_mag(macc_r[FRACTION_BITS +: 64], neg_r);
        sat_nxt = fm[64];
        res_nxt = fm[63:0];
      end
    end else if (cmd.exec && op_cur_r == OP_ADD) begin
      if (a_r[63] == b_r[63] && sum_ab[63] != a_r[63]) begin
        sat_nxt = 1'b1;
        res_nxt = a_r[63] ? SIGN_MIN : SIGN_MAX;
      end else begin
        res_nxt = sum_ab;
      end
    end else if (cmd.exec && op_cur_r == OP_SUB) begin
      if (a_r[63] != b_r[63] && dif_ab[63] != a_r[63]) begin
        sat_nxt = 1'b1;
        res_nxt = a_r[63] ? SIGN_MIN : SIGN_MAX;
      end else begin
        res_nxt = dif_ab;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  // error tracking, at most one source per cycle
  always_comb begin
    err_nxt = err_r;
    if (cmd.emit) err_nxt = ERR_OK;
    else if (cmd.add_point && seen_eff) err_nxt = flag(err_r, ERR_BAD_CHAR);
    else if (cmd.flag_bad) err_nxt = flag(err_r, ERR_BAD_CHAR);
    else if (cmd.flag_miss) err_nxt = flag(err_r, ERR_OPERAND);
    else if ((cmd.push_zero || cmd.conv_push || cmd.push_res) && !fatal && vfull)
      err_nxt = flag(err_r, ERR_OVERFLOW);
    else if ((cmd.push_lpar || cmd.push_op) && !fatal && ofull)
      err_nxt = flag(err_r, ERR_OVERFLOW);
    else if (cmd.exec && st.div_zero) err_nxt = flag(err_r, ERR_DIV_ZERO);
    else if (sat_nxt) err_nxt = flag(err_r, ERR_SATURATED);
  end

  // number being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      fd_r     <= '0;
      innum_r  <= 1'b0;
      seen_r   <= 1'b0;
      expect_r <= 1'b1;
      err_r    <= ERR_OK;
    end else begin
      err_r <= err_nxt;
      if (cmd.emit) begin
        acc_r    <= '0;
        fd_r     <= '0;
        innum_r  <= 1'b0;
        seen_r   <= 1'b0;
        expect_r <= 1'b1;
      end else if (cmd.add_digit) begin
        innum_r <= 1'b1;
        seen_r  <= seen_eff;
        fd_r    <= fd_eff;
        if (dig_t > DIGIT_CAP) begin
          acc_r <= seen_eff ? acc_eff : DIGIT_CAP;
        end else if (seen_eff && fd_eff >= MAX_FRAC_DIGITS) begin
          acc_r <= acc_eff;
        end else begin
          acc_r <= dig_t;
          fd_r  <= fd_eff + 5'(seen_eff);
        end
      end else if (cmd.add_point) begin
        innum_r <= 1'b1;
        seen_r  <= 1'b1;
        acc_r   <= acc_eff;
        fd_r    <= fd_eff;
      end else if (cmd.conv_push) begin
        innum_r  <= 1'b0;
        seen_r   <= 1'b0;
        expect_r <= 1'b0;
        acc_r    <= '0;
        fd_r     <= '0;
      end else if (cmd.push_lpar || cmd.push_op) begin
        expect_r <= 1'b1;
      end else if (cmd.rpar_close) begin
        expect_r <= 1'b0;
      end
    end
  end

  // value stack
  assign do_vpush   = (cmd.push_zero || cmd.conv_push || cmd.push_res) && !fatal && !vfull;
  assign vpush_data = cmd.push_zero ? 64'd0 : res_r;

  always_ff @(posedge clk) begin
    if (do_vpush) vmem[vc_r[VAW-1:0]] <= vpush_data;
    if (cmd.val_rd_top) vrd_r <= vmem[vc_m1[VAW-1:0]];
    else if (cmd.val_rd_second) vrd_r <= vmem[vc_m2[VAW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= '0;
    end else if (cmd.emit) begin
      vc_r <= '0;
    end else if (do_vpush) begin
      vc_r <= vc_r + VCW'(1);
    end else if (cmd.cap_a) begin
      vc_r <= vc_m2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_b) b_r <= vrd_r;
    if (cmd.cap_a) a_r <= vrd_r;
  end

  // operator stack
  assign do_opush   = (cmd.push_lpar || cmd.push_op) && !fatal && !ofull;
  assign opush_code = cmd.push_lpar ? OP_LPAR : cop;

  always_ff @(posedge clk) begin
    if (do_opush) omem[oc_r[OAW-1:0]] <= opush_code;
    if (cmd.op_rd) ord_r <= omem[oc_m1[OAW-1:0]];
    if (cmd.op_pop) op_cur_r <= ord_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oc_r <= '0;
    end else if (cmd.emit) begin
      oc_r <= '0;
    end else if (do_opush) begin
      oc_r <= oc_r + OCW'(1);
    end else if (cmd.op_pop || (cmd.rpar_close && !fatal && oc_r != '0)) begin
      oc_r <= oc_m1;
    end
  end

  // multiplier: four 32x32 partial products, each registered before the add
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mdone_r <= 1'b0;
      mstep_r <= '0;
    end else begin
      mdone_r <= 1'b0;
      if (cmd.exec && op_cur_r == OP_MUL) begin
        mbusy_r <= 1'b1;
        mstep_r <= '0;
      end else if (mbusy_r) begin
        mstep_r <= mstep_r + 3'd1;
        if (mstep_r == 3'd4) begin
          mbusy_r <= 1'b0;
          mdone_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && op_cur_r == OP_MUL) begin
      mx_r   <= mag64(a_r);
      my_r   <= mag64(b_r);
      macc_r <= '0;
    end else if (mbusy_r) begin
      case (mstep_r[1:0])
        2'd0: begin
          prod_r <= mx_r[31:0] * my_r[31:0];
          psh_r  <= 2'd0;
        end
        2'd1: begin
          prod_r <= mx_r[31:0] * my_r[63:32];
          psh_r  <= 2'd1;
        end
        2'd2: begin
          prod_r <= mx_r[63:32] * my_r[31:0];
          psh_r  <= 2'd1;
        end
        default: begin
          prod_r <= mx_r[63:32] * my_r[63:32];
          psh_r  <= 2'd2;
        end
      endcase
      if (mstep_r != 3'd0) macc_r <= macc_r + (128'(prod_r) << {psh_r, 5'd0});
    end
  end

  // divider shared by number conversion and division
  assign div_start = cmd.conv_start || (cmd.exec && op_cur_r == OP_DIV && b_r != 64'd0);
  assign div_dvd   = cmd.conv_start ? (DVD_W'(acc_r) << FRACTION_BITS)
                                    : (DVD_W'(mag64(a_r)) << FRACTION_BITS);
  assign div_dsr   = cmd.conv_start ? p10 : mag64(b_r);

  always_ff @(posedge clk) begin
    if (cmd.conv_start) kind_conv_r <= 1'b1;
    else if (cmd.exec) begin
      kind_conv_r <= 1'b0;
      neg_r       <= a_r[63] ^ b_r[63];
    end
  end

  iee_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd   (div_dvd),
    .dsr   (div_dsr),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // result register
  assign emit_err = (!fatal && vc_r == '0) ? flag(err_r, ERR_OPERAND) : err_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_err_r   <= emit_err;
      out_value_r <= is_fatal(emit_err) ? 64'd0 : vrd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_err   = out_err_r;

  a_vc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r <= VCW'(VALUE_STACK_DEPTH))
    else $error("value count past stack depth");

  a_oc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    oc_r <= OCW'(OPERATOR_STACK_DEPTH))
    else $error("operator count past stack depth");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && vc_r == '0 && oc_r == '0 && err_r == ERR_OK)
    else $error("state not cleared after result");

endmodule

// ----- design/iee_ctrl.sv -----
// controller state machine: sequences character handling, reductions and result
// depends on iee_pkg; drives the datapath through cmd_t and reads sts_t
module iee_ctrl import iee_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t st,
  output cmd_t cmd
);

  typedef enum logic [16:0] {
    S_IDLE     = 17'b00000000000000001,
    S_CHAR     = 17'b00000000000000010,
    S_CONV     = 17'b00000000000000100,
    S_CONVPUSH = 17'b00000000000001000,
    S_DISPATCH = 17'b00000000000010000,
    S_OPRD     = 17'b00000000000100000,
    S_OPCHK    = 17'b00000000001000000,
    S_APPLY    = 17'b00000000010000000,
    S_RDB      = 17'b00000000100000000,
    S_RDA      = 17'b00000001000000000,
    S_EXEC     = 17'b00000010000000000,
    S_WAIT     = 17'b00000100000000000,
    S_PUSHR    = 17'b00001000000000000,
    S_LOOPEND  = 17'b00010000000000000,
    S_LASTCHK  = 17'b00100000000000000,
    S_RESULT   = 17'b01000000000000000,
    S_EMIT     = 17'b10000000000000000
  } state_t;

  typedef enum logic [1:0] {MODE_OP, MODE_RPAR, MODE_FINAL} mode_t;

  state_t state_r, state_nxt;
  mode_t  mode_r, mode_nxt;
  logic   fin_r, fin_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    mode_nxt  = mode_r;
    fin_nxt   = fin_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = st.fatal ? S_LASTCHK : S_CHAR;
        end
      end
      S_CHAR: begin
        if (st.cls == CLS_DIGIT) begin
          cmd.add_digit = 1'b1;
          state_nxt     = S_LASTCHK;
        end else if (st.cls == CLS_POINT) begin
          cmd.add_point = 1'b1;
          state_nxt     = S_LASTCHK;
        end else if (st.in_number) begin
          cmd.conv_start = 1'b1;
          fin_nxt        = 1'b0;
          state_nxt      = S_CONV;
        end else begin
          state_nxt = S_DISPATCH;
        end
      end
      S_CONV: begin
        if (st.unit_done) state_nxt = S_CONVPUSH;
      end
      S_CONVPUSH: begin
        cmd.conv_push = 1'b1;
        if (fin_r) begin
          mode_nxt  = MODE_FINAL;
          state_nxt = S_OPRD;
        end else begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.fatal) begin
          state_nxt = S_LASTCHK;
        end else begin
          case (st.cls)
            CLS_LPAR: begin
              cmd.push_lpar = 1'b1;
              state_nxt     = S_LASTCHK;
            end
            CLS_RPAR: begin
              mode_nxt  = MODE_RPAR;
              state_nxt = S_OPRD;
            end
            CLS_OP: begin
              // unary minus pushes a zero first
              cmd.push_zero = st.sub_expect;
              mode_nxt      = MODE_OP;
              state_nxt     = S_OPRD;
            end
            CLS_BAD: begin
              cmd.flag_bad = 1'b1;
              state_nxt    = S_LASTCHK;
            end
            default: state_nxt = S_LASTCHK;
          endcase
        end
      end
      S_OPRD: begin
        if (st.fatal || st.oc_zero) begin
          state_nxt = S_LOOPEND;
        end else begin
          cmd.op_rd = 1'b1;
          state_nxt = S_OPCHK;
        end
      end
      S_OPCHK: begin
        if ((mode_r == MODE_RPAR && st.top_lpar) || (mode_r == MODE_OP && !st.prec_ge)) begin
          state_nxt = S_LOOPEND;
        end else begin
          cmd.op_pop = 1'b1;
          state_nxt  = S_APPLY;
        end
      end
      S_APPLY: begin
        if (st.cur_lpar) begin
          state_nxt = S_OPRD;
        end else if (st.vc_lt2) begin
          cmd.flag_miss = 1'b1;
          state_nxt     = S_OPRD;
        end else begin
          cmd.val_rd_top = 1'b1;
          state_nxt      = S_RDB;
        end
      end
      S_RDB: begin
        cmd.cap_b         = 1'b1;
        cmd.val_rd_second = 1'b1;
        state_nxt         = S_RDA;
      end
      S_RDA: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (st.div_zero) state_nxt = S_OPRD;
        else if (st.long_op) state_nxt = S_WAIT;
        else state_nxt = S_PUSHR;
      end
      S_WAIT: begin
        if (st.unit_done) state_nxt = S_PUSHR;
      end
      S_PUSHR: begin
        cmd.push_res = 1'b1;
        state_nxt    = S_OPRD;
      end
      S_LOOPEND: begin
        case (mode_r)
          MODE_RPAR: begin
            cmd.rpar_close = 1'b1;
            state_nxt      = S_LASTCHK;
          end
          MODE_OP: begin
            cmd.push_op = 1'b1;
            state_nxt   = S_LASTCHK;
          end
          default: state_nxt = S_RESULT;
        endcase
      end
      S_LASTCHK: begin
        if (!st.last) begin
          state_nxt = S_IDLE;
        end else if (!st.fatal && st.in_number) begin
          cmd.conv_start = 1'b1;
          fin_nxt        = 1'b1;
          state_nxt      = S_CONV;
        end else begin
          mode_nxt  = MODE_FINAL;
          state_nxt = S_OPRD;
        end
      end
      S_RESULT: begin
        cmd.val_rd_top = 1'b1;
        state_nxt      = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      mode_r  <= MODE_OP;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
      fin_r   <= fin_nxt;
    end
  end

endmodule

// ----- design/infix_expression_evaluator_unit.sv -----
// infix expression evaluator, one character per request, Q31.32 result per expression
// a number ending starts the 128-step divider for its conversion; each reduction
// reads its two operands and applies the operator, '*' and '/' waiting on the
// multiplier or divider; the result register lets the next character in while a
// result waits; stacks hold no reset value
// reset: synchronous active-low rst_n clears counts, number state and error
module infix_expression_evaluator_unit import iee_pkg::*; #(
  parameter int VALUE_STACK_DEPTH    = VALUE_STACK_DEPTH_DEF,
  parameter int OPERATOR_STACK_DEPTH = OPERATOR_STACK_DEPTH_DEF,
  parameter int FRACTION_BITS        = FRACTION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // [63:0] result_value, [66:64] error_code, zero fill
);

  cmd_t        cmd;
  sts_t        st;
  logic [63:0] res_value;
  logic [2:0]  res_err;

  iee_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  iee_dp #(
    .VALUE_STACK_DEPTH    (VALUE_STACK_DEPTH),
    .OPERATOR_STACK_DEPTH (OPERATOR_STACK_DEPTH),
    .FRACTION_BITS        (FRACTION_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_char   (in_tdata),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_value (res_value),
    .out_err   (res_err)
  );

  assign out_tdata = {5'd0, res_err, res_value};

endmodule

// ----- dv/tb_infix_expression_evaluator_unit.sv -----
// testbench for infix_expression_evaluator_unit: drives expressions one character per
// request and checks each result against an internal shunting-yard evaluator
// depends on design/iee_pkg.sv and design/infix_expression_evaluator_unit.sv
`timescale 1ns / 1ps

module tb_infix_expression_evaluator_unit;
  import iee_pkg::*;

  localparam int VDEPTH = 16;
  localparam int ODEPTH = 16;
  localparam int FB     = 32;
  localparam int CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  err;
  } eval_result_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       has_want;
    logic [63:0] want_value;
    logic [2:0]  want_err;
  } char_row_t;

  eval_result_t pending_results[$];
  eval_result_t typed_results[$];
  logic         typed_flag[$];
  char_row_t    rows[$];

  int mismatches;
  int cycles;

  // evaluator state
  logic [63:0] vstk[VDEPTH];
  int          vcnt;
  logic [2:0]  ostk[ODEPTH];
  int          ocnt;
  logic [63:0] acc;
  int          fdig;
  bit          innum;
  bit          seenpt;
  bit          expop;
  logic [2:0]  sticky;

  function automatic bit fatal_now();
    return sticky >= ERR_OVERFLOW && sticky <= ERR_BAD_CHAR;
  endfunction

  function automatic void raise(logic [2:0] e);
    if (e == ERR_SATURATED) begin
      if (sticky == ERR_OK) sticky = ERR_SATURATED;
    end else if (sticky == ERR_OK || sticky == ERR_SATURATED) begin
      sticky = e;
    end
  endfunction

  function automatic logic [63:0] sat(bit neg);
    raise(ERR_SATURATED);
    return neg ? SIGN_MIN : SIGN_MAX;
  endfunction

  function automatic logic [63:0] signed_of(logic [63:0] m, bit neg);
    logic [63:0] lim;
    lim = neg ? SIGN_MIN : SIGN_MAX;
    if (m > lim) return sat(neg);
    return neg ? 64'd0 - m : m;
  endfunction

  function automatic logic [63:0] absval(logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  function automatic void eval_reset();
    vcnt = 0; ocnt = 0; acc = 0; fdig = 0;
    innum = 0; seenpt = 0; expop = 1; sticky = ERR_OK;
  endfunction

  function automatic void push_val(logic [63:0] v);
    if (fatal_now()) return;
    if (vcnt >= VDEPTH) begin
      raise(ERR_OVERFLOW);
      return;
    end
    vstk[vcnt] = v;
    vcnt++;
  endfunction

  function automatic void push_op(logic [2:0] o);
    if (fatal_now()) return;
    if (ocnt >= ODEPTH) begin
      raise(ERR_OVERFLOW);
      return;
    end
    ostk[ocnt] = o;
    ocnt++;
  endfunction

  function automatic logic [63:0] decimal_to_fixed(logic [63:0] m, int fd);
    logic [63:0] d, q, r, f, v;
    d = 64'd1;
    for (int i = 0; i < (fd < 18 ? fd : 18); i++) d = d * 10;
    q = m / d;
    r = m % d;
    f = 0;
    if (q >= (64'd1 << (63 - FB))) return sat(0);
    for (int i = 0; i < FB; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= d) begin
        r = r - d;
        f[0] = 1'b1;
      end
    end
    if ({r, 1'b0} >= {1'b0, d}) f = f + 1;
    v = (q << FB) + f;
    if (v > SIGN_MAX) return sat(0);
    return v;
  endfunction

  function automatic logic [63:0] fixed_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    bit neg;
    neg = a[63] ^ b[63];
    p = absval(a) * absval(b);
    if ((p >> (64 + FB)) != 0) return sat(neg);
    return signed_of(p[FB +: 64], neg);
  endfunction

  function automatic logic [63:0] fixed_div(logic [63:0] a, logic [63:0] b);
    logic [127:0] q;
    bit neg;
    neg = a[63] ^ b[63];
    q = ({64'd0, absval(a)} << FB) / {64'd0, absval(b)};
    if (q[127:64] != 0) return sat(neg);
    return signed_of(q[63:0], neg);
  endfunction

  function automatic void reduce(logic [2:0] o);
    logic [63:0] a, b, r, s;
    if (o == OP_LPAR) return;
    if (vcnt < 2) begin
      raise(ERR_OPERAND);
      return;
    end
    vcnt--; b = vstk[vcnt];
    vcnt--; a = vstk[vcnt];
    case (o)
      OP_ADD: begin
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) r = sat(a[63]);
      end
      OP_SUB: begin
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) r = sat(a[63]);
      end
      OP_MUL: r = fixed_mul(a, b);
      default: begin
        if (b == 0) begin
          raise(ERR_DIV_ZERO);
          return;
        end
        r = fixed_div(a, b);
      end
    endcase
    push_val(r);
  endfunction

  function automatic int rank(logic [2:0] o);
    if (o == OP_ADD || o == OP_SUB) return 1;
    if (o == OP_MUL || o == OP_DIV) return 2;
    return 0;
  endfunction

  function automatic void close_number();
    logic [63:0] v;
    v = decimal_to_fixed(acc, fdig);
    innum = 0; seenpt = 0; expop = 0; acc = 0; fdig = 0;
    push_val(v);
  endfunction

  function automatic void open_number();
    if (innum) return;
    innum = 1; seenpt = 0; acc = 0; fdig = 0;
  endfunction

  function automatic void take_char(logic [7:0] c);
    logic [2:0] o;
    logic [63:0] d;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      open_number();
      if (acc > (DIGIT_CAP - d) / 10) begin
        if (!seenpt) acc = DIGIT_CAP;
        return;
      end
      if (seenpt && fdig >= 18) return;
      acc = acc * 10 + d;
      if (seenpt) fdig++;
      return;
    end
    if (c == CH_POINT) begin
      open_number();
      if (seenpt) raise(ERR_BAD_CHAR);
      else seenpt = 1;
      return;
    end
    if (innum) close_number();
    if (fatal_now()) return;
    if (c == CH_SPACE) return;
    if (c == CH_LPAR) begin
      push_op(OP_LPAR);
      expop = 1;
      return;
    end
    if (c == CH_RPAR) begin
      while (ocnt > 0 && !fatal_now() && ostk[ocnt - 1] != OP_LPAR) begin
        ocnt--;
        reduce(ostk[ocnt]);
      end
      if (!fatal_now() && ocnt > 0) ocnt--;
      expop = 0;
      return;
    end
    case (c)
      CH_PLUS:  o = OP_ADD;
      CH_MINUS: o = OP_SUB;
      CH_STAR:  o = OP_MUL;
      CH_SLASH: o = OP_DIV;
      default: begin
        raise(ERR_BAD_CHAR);
        return;
      end
    endcase
    if (o == OP_SUB && expop) push_val(64'd0);
    while (ocnt > 0 && !fatal_now() && rank(ostk[ocnt - 1]) >= rank(o)) begin
      ocnt--;
      reduce(ostk[ocnt]);
    end
    push_op(o);
    expop = 1;
  endfunction

  // returns 1 when the request ends an expression and fills res
  function automatic bit eval_char(logic [7:0] c, logic last, output eval_result_t res);
    res = '0;
    if (!fatal_now()) take_char(c);
    if (!last) return 0;
    if (!fatal_now() && innum) close_number();
    while (ocnt > 0 && !fatal_now()) begin
      ocnt--;
      reduce(ostk[ocnt]);
    end
    if (!fatal_now()) begin
      if (vcnt == 0) raise(ERR_OPERAND);
      else res.value = vstk[vcnt - 1];
    end
    if (fatal_now()) res.value = 0;
    res.err = sticky;
    eval_reset();
    return 1;
  endfunction

  infix_expression_evaluator_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic void add_text(string s, bit typed = 0,
                                   logic [63:0] v = 0, logic [2:0] e = ERR_OK);
    char_row_t r;
    for (int i = 0; i < s.len(); i++) begin
      r.ch = s[i];
      r.last = (i == s.len() - 1);
      r.has_want = typed && r.last;
      r.want_value = v;
      r.want_err = e;
      rows.push_back(r);
    end
  endfunction

  function automatic void add_raw(logic [7:0] c, logic last);
    char_row_t r;
    r.ch = c; r.last = last; r.has_want = 0; r.want_value = 0; r.want_err = ERR_OK;
    rows.push_back(r);
  endfunction

  function automatic string rand_number();
    string s;
    int n;
    s = "";
    n = $urandom_range(1, 3);
    if ($urandom_range(0, 19) == 0) n = $urandom_range(8, 22);
    for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    if ($urandom_range(0, 3) == 0) begin
      s = {s, "."};
      n = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) n = 20;
      for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
    end
    return s;
  endfunction

  function automatic string rand_expr(int depth);
    string s, ops;
    int terms;
    ops = "+-*/";
    s = "";
    terms = $urandom_range(1, 4);
    for (int t = 0; t < terms; t++) begin
      if (t > 0) begin
        if ($urandom_range(0, 2) == 0) s = {s, " "};
        s = {s, string'(ops[$urandom_range(0, 3)])};
      end
      if ($urandom_range(0, 5) == 0) s = {s, "-"};
      if (depth < 3 && $urandom_range(0, 4) == 0) s = {s, "(", rand_expr(depth + 1), ")"};
      else s = {s, rand_number()};
    end
    return s;
  endfunction

  // directed rows, then random expressions with some noise
  function automatic void build_stimulus();
    string s;
    int k;
    add_text("0", 1, 64'd0, ERR_OK);
    add_text("1+2*3", 1, 64'd7 << 32, ERR_OK);
    add_text("-5", 1, 64'd0 - (64'd5 << 32), ERR_OK);
    add_text("(1+2)*3-4/2");
    add_text("7/2");
    add_text("0.5 - .25");
    add_text("1/0", 1, 64'd0, ERR_DIV_ZERO);
    add_text("2#", 1, 64'd0, ERR_BAD_CHAR);
    add_text("1.2.3", 1, 64'd0, ERR_BAD_CHAR);
    add_text("*", 1, 64'd0, ERR_OPERAND);
    add_text(" ", 1, 64'd0, ERR_OPERAND);
    add_text("2147483648", 1, SIGN_MAX, ERR_SATURATED);
    add_text("9999999999999999999999");
    add_text("1.0000000000000000000009");
    add_text("2147483647*2147483647");
    add_text("2 3");
    add_text("(3");
    add_text("3)+1");
    add_text("(((((((((((((((((1", 1, 64'd0, ERR_OVERFLOW);
    add_text("1/3");
    add_text(".");
    add_raw(8'hFF, 0); add_raw(8'h80, 1);
    while (rows.size() < 875) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        // noise of arbitrary bytes
        for (int i = $urandom_range(1, 4); i > 0; i--) add_raw(8'($urandom), 0);
        add_raw(8'($urandom), 1);
      end else begin
        s = rand_expr(0);
        if (k == 1 && s.len() > 1) s[$urandom_range(0, s.len() - 1)] = 8'($urandom_range(32, 127));
        add_text(s);
      end
    end
  endfunction

  // sender: bursts and gaps
  initial begin
    eval_result_t res;
    int burst;
    int gap;
    in_tvalid = 0;
    in_tdata = 0;
    in_tlast = 0;
    rst_n = 0;
    mismatches = 0;
    eval_reset();
    build_stimulus();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    burst = 0;
    foreach (rows[i]) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
        if (gap > 0) begin
          in_tvalid <= 0;
          repeat (gap) @(negedge clk);
        end
        burst = $urandom_range(1, 40);
      end
      burst--;
      in_tvalid <= 1;
      in_tdata <= rows[i].ch;
      in_tlast <= rows[i].last;
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      if (eval_char(rows[i].ch, rows[i].last, res)) begin
        pending_results.push_back(res);
        typed_flag.push_back(rows[i].has_want);
        typed_results.push_back({rows[i].want_value, rows[i].want_err});
      end
      @(negedge clk);
    end
    in_tvalid <= 0;
    while (pending_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // receiver: own stall pattern plus one long hold-off
  initial begin
    int n;
    out_tready = 0;
    wait (rst_n);
    n = 0;
    forever begin
      @(negedge clk);
      n++;
      if (n >= 3000 && n < 9000) out_tready <= 0;
      else if (n % 500 < 150) out_tready <= 1;
      else out_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    eval_result_t want, got;
    cycles <= cycles + 1;
    if (rst_n && out_tvalid && out_tready) begin
      got.value = out_tdata[63:0];
      got.err = out_tdata[66:64];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h err %0d", got.value, got.err);
      end else begin
        want = pending_results.pop_front();
        if (typed_flag.pop_front() && typed_results[0] != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("table row disagrees: row %h/%0d model %h/%0d",
                     typed_results[0].value, typed_results[0].err, want.value, want.err);
        end
        void'(typed_results.pop_front());
        if (got.value != want.value || got.err != want.err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: expected %h err %0d, got %h err %0d",
                     want.value, want.err, got.value, got.err);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    wait (cycles >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule
